/* rtl/text_mode_console_writer_top_assert.svh */
// Assertion macros used by the console writer sequencer.
`ifndef TEXT_MODE_CONSOLE_WRITER_TOP_ASSERT_SVH
`define TEXT_MODE_CONSOLE_WRITER_TOP_ASSERT_SVH

// Check a property at every rising clock edge outside reset.
`define TMCW_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define TMCW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/tmcw_pkg.sv */
// Shared types and constants for the text-mode console writer.
`default_nettype none

package tmcw_pkg;

	localparam int CHAR_W    = 8;
	localparam int CELL_W    = 16;
	localparam int INDEX_W   = 11;
	localparam int ROW_OUT_W = 5;
	localparam int COL_OUT_W = 7;
	localparam int POS_OUT_W = 11;

	localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
	localparam logic [CHAR_W-1:0] CHAR_RETURN  = 8'd13;
	localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'd32;
	localparam logic [CHAR_W-1:0] RESET_COLOR  = 8'd7;

	localparam logic CMD_PUT  = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef struct packed {
		logic [ROW_OUT_W-1:0] cursor_row;
		logic [COL_OUT_W-1:0] cursor_column;
		logic [POS_OUT_W-1:0] cursor_position;
		logic [CELL_W-1:0]    cell_value;
	} result_t;

endpackage

`default_nettype wire

/* rtl/tmcw_in_if.sv */
// Command channel of the console writer: valid, ready and one command word.
`default_nettype none

interface tmcw_in_if;
	logic                         valid;
	logic                         ready;
	logic                         cmd;
	logic [tmcw_pkg::CHAR_W-1:0]  char_code;
	logic [tmcw_pkg::INDEX_W-1:0] cell_index;

	modport source (output valid, output cmd, output char_code, output cell_index,
		input ready);
	modport sink (input valid, input cmd, input char_code, input cell_index,
		output ready);
endinterface

`default_nettype wire

/* rtl/tmcw_out_if.sv */
// Result channel of the console writer: valid, ready and one result word.
`default_nettype none

interface tmcw_out_if;
	logic                           valid;
	logic                           ready;
	logic [tmcw_pkg::ROW_OUT_W-1:0] cursor_row;
	logic [tmcw_pkg::COL_OUT_W-1:0] cursor_column;
	logic [tmcw_pkg::POS_OUT_W-1:0] cursor_position;
	logic [tmcw_pkg::CELL_W-1:0]    cell_value;

	modport source (output valid, output cursor_row, output cursor_column,
		output cursor_position, output cell_value, input ready);
	modport sink (input valid, input cursor_row, input cursor_column,
		input cursor_position, input cell_value, output ready);
endinterface

`default_nettype wire

/* rtl/tmcw_screen_ram.sv */
// Screen cell memory: one write port, one registered read port.
`default_nettype none

module tmcw_screen_ram #(
	parameter  int DEPTH = 2000,
	localparam int AW    = $clog2(DEPTH)
) (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic [AW-1:0]               waddr,
	input  wire logic [tmcw_pkg::CELL_W-1:0] wdata,
	input  wire logic                        re,
	input  wire logic [AW-1:0]               raddr,
	output      logic [tmcw_pkg::CELL_W-1:0] rdata
);

	logic [tmcw_pkg::CELL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// hold the last word read until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/tmcw_seq.sv */
// Console sequencer: cursor, command decode, clear and scroll sweeps.
`default_nettype none
`include "text_mode_console_writer_top_assert.svh"

module tmcw_seq #(
	parameter  int SCREEN_COLUMNS = 80,
	parameter  int SCREEN_ROWS    = 25,
	localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS,
	localparam int AW             = $clog2(CELL_COUNT)
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [tmcw_pkg::CHAR_W-1:0]  text_color,
	input  wire logic                         item_valid,
	output      logic                         item_ready,
	input  wire logic                         cmd,
	input  wire logic [tmcw_pkg::CHAR_W-1:0]  char_code,
	input  wire logic [tmcw_pkg::INDEX_W-1:0] cell_index,
	input  wire logic                         result_room,
	output      logic                         result_load,
	output      tmcw_pkg::result_t            result,
	output      logic                         ram_we,
	output      logic [AW-1:0]                ram_waddr,
	output      logic [tmcw_pkg::CELL_W-1:0]  ram_wdata,
	output      logic                         ram_re,
	output      logic [AW-1:0]                ram_raddr,
	input  wire logic [tmcw_pkg::CELL_W-1:0]  ram_rdata
);

	localparam int RW  = $clog2(SCREEN_ROWS);
	localparam int CLW = $clog2(SCREEN_COLUMNS);
	localparam int PW  = $clog2(CELL_COUNT);
	localparam int CW  = $clog2(CELL_COUNT + 1);

	localparam logic [CW-1:0]  CNT_COLS   = CW'(SCREEN_COLUMNS);
	localparam logic [CW-1:0]  CNT_CELLS  = CW'(CELL_COUNT);
	localparam logic [CW-1:0]  CNT_LAST   = CW'(CELL_COUNT - 1);
	localparam logic [CW-1:0]  CNT_BLANK  = CW'(CELL_COUNT - SCREEN_COLUMNS);
	localparam logic [RW-1:0]  ROW_LAST   = RW'(SCREEN_ROWS - 1);
	localparam logic [CLW-1:0] COL_LAST   = CLW'(SCREEN_COLUMNS - 1);
	localparam logic [PW-1:0]  POS_BOTTOM = PW'(CELL_COUNT - SCREEN_COLUMNS);
	localparam logic [PW-1:0]  POS_COLS   = PW'(SCREEN_COLUMNS);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_COPY,
		ST_BLANK,
		ST_FINISH
	} state_t;

	state_t               state_q;
	logic [CW-1:0]        cnt_q;
	logic [RW-1:0]        row_q;
	logic [CLW-1:0]       col_q;
	logic [PW-1:0]        pos_q;
	logic                 is_read_q;
	logic                 in_range_q;
	logic                 valid_s1;
	logic [AW-1:0]        waddr_s1;

	logic                 accept;
	logic                 in_range;
	logic                 printable;
	logic [RW-1:0]        nx_row;
	logic [CLW-1:0]       nx_col;
	logic [PW-1:0]        nx_pos;
	logic                 nx_scroll;
	logic                 cursor_ok;

	assign item_ready  = (state_q == ST_IDLE);
	assign accept      = item_valid && item_ready;
	assign in_range    = 32'(cell_index) < CELL_COUNT;
	assign printable   = (char_code != tmcw_pkg::CHAR_NEWLINE) &&
		(char_code != tmcw_pkg::CHAR_RETURN);
	assign result_load = (state_q == ST_FINISH) && result_room;

	// cursor after a put; the linear position follows by adds and subtracts alone
	always_comb begin
		nx_row    = row_q;
		nx_col    = col_q;
		nx_pos    = pos_q;
		nx_scroll = 1'b0;
		if (char_code == tmcw_pkg::CHAR_RETURN) begin
			nx_col = '0;
			nx_pos = pos_q - PW'(col_q);
		end else if (char_code == tmcw_pkg::CHAR_NEWLINE || col_q == COL_LAST) begin
			nx_col = '0;
			if (row_q == ROW_LAST) begin
				nx_scroll = 1'b1;
				nx_pos    = POS_BOTTOM;
			end else begin
				nx_row = row_q + RW'(1);
				nx_pos = pos_q - PW'(col_q) + POS_COLS;
			end
		end else begin
			nx_col = col_q + CLW'(1);
			nx_pos = pos_q + PW'(1);
		end
	end

	// memory port steering per state
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(cnt_q);
				ram_wdata = {tmcw_pkg::RESET_COLOR, tmcw_pkg::CHAR_SPACE};
			end
			ST_IDLE: begin
				if (accept && cmd == tmcw_pkg::CMD_READ) begin
					ram_re    = in_range;
					ram_raddr = AW'(cell_index);
				end else if (accept && printable) begin
					ram_we    = 1'b1;
					ram_waddr = AW'(pos_q);
					ram_wdata = {text_color, char_code};
				end
			end
			ST_COPY: begin
				ram_we    = valid_s1;
				ram_waddr = waddr_s1;
				ram_wdata = ram_rdata;
				if (cnt_q != CNT_CELLS) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(cnt_q);
				end
			end
			ST_BLANK: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(cnt_q);
				ram_wdata = {text_color, tmcw_pkg::CHAR_SPACE};
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		result.cursor_row      = tmcw_pkg::ROW_OUT_W'(row_q);
		result.cursor_column   = tmcw_pkg::COL_OUT_W'(col_q);
		result.cursor_position = tmcw_pkg::POS_OUT_W'(pos_q);
		result.cell_value      = (is_read_q && in_range_q) ? ram_rdata : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			cnt_q      <= '0;
			row_q      <= '0;
			col_q      <= '0;
			pos_q      <= '0;
			is_read_q  <= 1'b0;
			in_range_q <= 1'b0;
			valid_s1   <= 1'b0;
			waddr_s1   <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CNT_LAST) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						is_read_q  <= (cmd == tmcw_pkg::CMD_READ);
						in_range_q <= in_range;
						if (cmd == tmcw_pkg::CMD_READ) begin
							state_q <= ST_READ;
						end else begin
							row_q <= nx_row;
							col_q <= nx_col;
							pos_q <= nx_pos;
							if (nx_scroll) begin
								cnt_q   <= CNT_COLS;
								state_q <= ST_COPY;
							end else begin
								state_q <= ST_FINISH;
							end
						end
					end
				end
				ST_READ: begin
					state_q <= ST_FINISH;
				end
				ST_COPY: begin
					// each word read lands one row up on the next cycle
					valid_s1 <= (cnt_q != CNT_CELLS);
					waddr_s1 <= AW'(cnt_q - CNT_COLS);
					if (cnt_q != CNT_CELLS) begin
						cnt_q <= cnt_q + CW'(1);
					end else begin
						cnt_q   <= CNT_BLANK;
						state_q <= ST_BLANK;
					end
				end
				ST_BLANK: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (result_room) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// row and column stay on the screen and in step with the linear position
	assign cursor_ok = (32'(row_q) < SCREEN_ROWS) && (32'(col_q) < SCREEN_COLUMNS) &&
		(32'(pos_q) == 32'(row_q) * SCREEN_COLUMNS + 32'(col_q));

	`TMCW_ASSERT(a_write_in_range, !ram_we || (32'(ram_waddr) < CELL_COUNT), "write off screen")
	`TMCW_ASSERT(a_cursor_consistent, cursor_ok, "cursor position out of step")
	`TMCW_ASSERT_NEXT(a_copy_pipe, (state_q == ST_COPY) && ram_re, valid_s1, "scroll word lost")
	`TMCW_ASSERT(a_read_no_write, !(accept && cmd) || !ram_we, "read command wrote the screen")

endmodule

`default_nettype wire

/* rtl/text_mode_console_writer_top.sv */
// Top level of the text-mode console writer.
// A put passes through the finish state, a read through the read and finish states,
// before the result word is loaded; no new command is taken until the return to idle.
// A scrolling put first copies each row below the top one row up, then blanks the bottom row.
// After reset a clearing pass fills the screen with grey spaces; no command is taken
// meanwhile, colour writes still are.
`default_nettype none

module text_mode_console_writer_top #(
	parameter int SCREEN_COLUMNS = 80,
	parameter int SCREEN_ROWS    = 25
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_wr_en,
	input  wire logic [tmcw_pkg::CHAR_W-1:0] cfg_wr_data,
	tmcw_in_if.sink                          in_ch,
	tmcw_out_if.source                       out_ch
);

	localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
	localparam int AW         = $clog2(CELL_COUNT);

	// colour register: attribute for characters and scroll blanks
	logic [tmcw_pkg::CHAR_W-1:0] text_color_q;

	// result word register, parts the sequencer from the sink
	logic                        out_valid_q;
	tmcw_pkg::result_t           out_word_q;

	logic                        result_room;
	logic                        result_load;
	tmcw_pkg::result_t           result;

	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [tmcw_pkg::CELL_W-1:0] ram_wdata;
	logic                        ram_re;
	logic [AW-1:0]               ram_raddr;
	logic [tmcw_pkg::CELL_W-1:0] ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= tmcw_pkg::RESET_COLOR;
		end else if (cfg_wr_en) begin
			text_color_q <= cfg_wr_data;
		end
	end

	// room when empty, or when the waiting word leaves this cycle
	assign result_room = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload holds while the sink stalls
	always_ff @(posedge clk) begin
		if (result_load) begin
			out_word_q <= result;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.cursor_row      = out_word_q.cursor_row;
	assign out_ch.cursor_column   = out_word_q.cursor_column;
	assign out_ch.cursor_position = out_word_q.cursor_position;
	assign out_ch.cell_value      = out_word_q.cell_value;

	// cursor, command decode and the clear/scroll sweeps
	tmcw_seq #(
		.SCREEN_COLUMNS (SCREEN_COLUMNS),
		.SCREEN_ROWS    (SCREEN_ROWS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_color  (text_color_q),
		.item_valid  (in_ch.valid),
		.item_ready  (in_ch.ready),
		.cmd         (in_ch.cmd),
		.char_code   (in_ch.char_code),
		.cell_index  (in_ch.cell_index),
		.result_room (result_room),
		.result_load (result_load),
		.result      (result),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_re      (ram_re),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata)
	);

	// screen cells, one word per cell
	tmcw_screen_ram #(
		.DEPTH (CELL_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for the text-mode console writer: directed table, then random traffic.
`timescale 1ns / 1ps

module testbench;
	import tmcw_pkg::*;

	localparam int COLS        = 80;
	localparam int ROWS        = 25;
	localparam int CELLS       = COLS * ROWS;
	localparam int TOP_INDEX   = (1 << INDEX_W) - 1;
	localparam int PHASES      = 5;
	localparam int PHASE_WORDS = 300;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 10000000;
	localparam bit TYPED       = 1'b1;
	localparam bit PRED        = 1'b0;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [CHAR_W-1:0] cfg_wr_data;

	tmcw_in_if  cmd_if ();
	tmcw_out_if res_if ();

	text_mode_console_writer_top #(
		.SCREEN_COLUMNS(COLS),
		.SCREEN_ROWS   (ROWS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_ch      (cmd_if),
		.out_ch     (res_if)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow copy of the console: screen, cursor and current attribute byte.
	logic [CELL_W-1:0] screen_model [CELLS];
	int                cur_row;
	int                cur_col;
	logic [CHAR_W-1:0] text_attr;

	// Reply words still owed by the block, oldest first.
	result_t console_replies [$];

	int  error_count  = 0;
	int  cycle_count  = 0;
	int  words_sent   = 0;
	int  cmd_idle_pct = 0;
	bit  hold_request = 1'b0;

	// One row of the opening script; the typed columns are used only where TYPED is set.
	typedef struct {
		logic              cmd;
		logic [CHAR_W-1:0] ch;
		int                idx;
		bit                typed;
		int                row;
		int                col;
		int                want_cell;
	} script_row_t;

	// Reset colour is grey (0x07), so a written byte reads back as 0x07xx.
	script_row_t opening_script [24] = '{
		'{CMD_READ, 8'h00,        0,         TYPED, 0, 0, 16'h0720}, // cleared screen
		'{CMD_READ, 8'h00,        CELLS - 1, TYPED, 0, 0, 16'h0720}, // last cell
		'{CMD_READ, 8'hFF,        CELLS,     TYPED, 0, 0, 16'h0000}, // just off the screen
		'{CMD_READ, 8'h00,        TOP_INDEX, TYPED, 0, 0, 16'h0000}, // largest index
		'{CMD_PUT,  8'h41,        0,         TYPED, 0, 1, 16'h0000},
		'{CMD_READ, 8'h00,        0,         TYPED, 0, 1, 16'h0741},
		'{CMD_PUT,  8'h00,        TOP_INDEX, TYPED, 0, 2, 16'h0000}, // byte zero prints
		'{CMD_PUT,  8'hFF,        0,         TYPED, 0, 3, 16'h0000},
		'{CMD_READ, 8'h00,        1,         TYPED, 0, 3, 16'h0700},
		'{CMD_READ, 8'h00,        2,         TYPED, 0, 3, 16'h07FF},
		'{CMD_PUT,  CHAR_RETURN,  0,         TYPED, 0, 0, 16'h0000},
		'{CMD_PUT,  8'h42,        0,         PRED,  0, 0, 0},        // overwrite cell 0
		'{CMD_READ, 8'h00,        0,         PRED,  0, 0, 0},
		'{CMD_READ, 8'h00,        1,         PRED,  0, 0, 0},
		'{CMD_PUT,  CHAR_NEWLINE, 0,         TYPED, 1, 0, 16'h0000},
		'{CMD_PUT,  CHAR_NEWLINE, 0,         TYPED, 2, 0, 16'h0000},
		'{CMD_PUT,  8'h7F,        0,         PRED,  0, 0, 0},
		'{CMD_PUT,  CHAR_SPACE,   0,         PRED,  0, 0, 0},
		'{CMD_PUT,  CHAR_RETURN,  0,         TYPED, 2, 0, 16'h0000},
		'{CMD_READ, 8'h00,        160,       PRED,  0, 0, 0},
		'{CMD_READ, 8'h00,        161,       PRED,  0, 0, 0},
		'{CMD_READ, 8'h00,        80,        TYPED, 2, 0, 16'h0720}, // skipped row stays blank
		'{CMD_PUT,  8'h80,        0,         PRED,  0, 0, 0},
		'{CMD_READ, 8'h00,        160,       PRED,  0, 0, 0}
	};

	task automatic report_mismatch(input string msg);
		// Print only the first hundred so a broken block cannot flood the log.
		if (error_count < 100)
			$display("MISMATCH @%0t: %s", $time, msg);
		error_count++;
	endtask

	// Advance the shadow console by one command and return the reply it owes.
	function automatic result_t predict_console(input logic cmd, input logic [CHAR_W-1:0] ch,
			input logic [INDEX_W-1:0] idx);
		result_t word;
		word.cell_value = '0;
		if (cmd == CMD_PUT) begin
			if (ch == CHAR_NEWLINE) begin
				cur_row++;
				cur_col = 0;
			end else if (ch == CHAR_RETURN) begin
				cur_col = 0;
			end else begin
				screen_model[cur_row * COLS + cur_col] = {text_attr, ch};
				cur_col++;
				if (cur_col >= COLS) begin
					cur_col = 0;
					cur_row++;
				end
			end
			// Past the bottom: shift every row up and blank the last in the current colour.
			if (cur_row >= ROWS) begin
				for (int k = 0; k < CELLS - COLS; k++)
					screen_model[k] = screen_model[k + COLS];
				for (int k = CELLS - COLS; k < CELLS; k++)
					screen_model[k] = {text_attr, CHAR_SPACE};
				cur_row = ROWS - 1;
			end
		end else if (idx < CELLS) begin
			word.cell_value = screen_model[idx];
		end
		word.cursor_row      = ROW_OUT_W'(cur_row);
		word.cursor_column   = COL_OUT_W'(cur_col);
		word.cursor_position = POS_OUT_W'(cur_row * COLS + cur_col);
		return word;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Read target: off the screen now and then, anywhere, or just behind the cursor.
	function automatic logic [INDEX_W-1:0] pick_cell();
		int r;
		int spot;
		r = $urandom_range(0, 9);
		if (r == 0)
			return INDEX_W'($urandom_range(CELLS, TOP_INDEX));
		if (r < 4)
			return INDEX_W'($urandom_range(0, CELLS - 1));
		spot = cur_row * COLS + cur_col - int'($urandom_range(0, 100));
		if (spot < 0)
			spot = $urandom_range(CELLS - COLS, CELLS - 1);
		return INDEX_W'(spot);
	endfunction

	// Offer one command word, hold it until taken, then log the reply it owes.
	task automatic send_word(input logic cmd, input logic [CHAR_W-1:0] ch,
			input logic [INDEX_W-1:0] idx, input bit typed = PRED, input result_t typed_word = '0);
		result_t predicted;
		if ($urandom_range(0, 99) < cmd_idle_pct) begin
			// Idle with junk on the payload lines; it must be ignored.
			repeat (gap_len()) begin
				@(negedge clk);
				cmd_if.valid      <= 1'b0;
				cmd_if.cmd        <= 1'($urandom);
				cmd_if.char_code  <= CHAR_W'($urandom);
				cmd_if.cell_index <= INDEX_W'($urandom);
			end
		end
		@(negedge clk);
		cmd_if.valid      <= 1'b1;
		cmd_if.cmd        <= cmd;
		cmd_if.char_code  <= ch;
		cmd_if.cell_index <= idx;
		do
			@(posedge clk);
		while (cmd_if.ready !== 1'b1);
		predicted = predict_console(cmd, ch, idx);
		console_replies.push_back(typed ? typed_word : predicted);
		words_sent++;
	endtask

	// Printable bytes only; 10 and 13 are turned into spaces so the line keeps going.
	task automatic type_text(input int count);
		logic [CHAR_W-1:0] glyph;
		repeat (count) begin
			glyph = CHAR_W'($urandom_range(0, 255));
			if (glyph == CHAR_NEWLINE || glyph == CHAR_RETURN)
				glyph = CHAR_SPACE;
			send_word(CMD_PUT, glyph, INDEX_W'($urandom));
		end
	endtask

	// One stretch of console traffic: a line of text, a burst of reads, blank lines or noise.
	task automatic run_segment();
		int kind;
		int tail;
		kind = $urandom_range(0, 99);
		case ($urandom_range(0, 2))
			0: cmd_idle_pct = 0;
			1: cmd_idle_pct = 15;
			default: cmd_idle_pct = 50;
		endcase
		if (kind < 45) begin
			type_text(($urandom_range(0, 9) == 0) ? $urandom_range(60, 170) : $urandom_range(1, 30));
			tail = $urandom_range(0, 9);
			if (tail < 7 && tail >= 5)
				send_word(CMD_PUT, CHAR_RETURN, INDEX_W'($urandom));
			if (tail >= 7 && tail < 9)
				send_word(CMD_PUT, CHAR_RETURN, INDEX_W'($urandom));
			if (tail < 5 || (tail >= 7 && tail < 9))
				send_word(CMD_PUT, CHAR_NEWLINE, INDEX_W'($urandom));
		end else if (kind < 70) begin
			repeat ($urandom_range(1, 8))
				send_word(CMD_READ, CHAR_W'($urandom), pick_cell());
		end else if (kind < 85) begin
			repeat ($urandom_range(1, 4))
				send_word(CMD_PUT, CHAR_NEWLINE, INDEX_W'($urandom));
		end else begin
			repeat ($urandom_range(1, 6))
				send_word(1'($urandom), CHAR_W'($urandom),
					INDEX_W'($urandom_range(0, TOP_INDEX)));
		end
	endtask

	// Drop valid and wait until every owed reply has come back.
	task automatic settle();
		@(negedge clk);
		cmd_if.valid <= 1'b0;
		while (console_replies.size() != 0)
			@(posedge clk);
	endtask

	// Colour writes go in only while the console is quiet.
	task automatic set_colour(input logic [CHAR_W-1:0] shade);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= shade;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		text_attr = shade;
	endtask

	// Compare a reply word with the oldest owed one, field by field.
	task automatic check_reply();
		result_t got;
		result_t want;
		got.cursor_row      = res_if.cursor_row;
		got.cursor_column   = res_if.cursor_column;
		got.cursor_position = res_if.cursor_position;
		got.cell_value      = res_if.cell_value;
		if (console_replies.size() == 0) begin
			report_mismatch($sformatf("reply word %h with nothing owed", got));
			return;
		end
		want = console_replies.pop_front();
		if (got.cursor_row !== want.cursor_row)
			report_mismatch($sformatf("cursor_row %0d, want %0d", got.cursor_row, want.cursor_row));
		if (got.cursor_column !== want.cursor_column)
			report_mismatch($sformatf("cursor_column %0d, want %0d",
				got.cursor_column, want.cursor_column));
		if (got.cursor_position !== want.cursor_position)
			report_mismatch($sformatf("cursor_position %0d, want %0d",
				got.cursor_position, want.cursor_position));
		if (got.cell_value !== want.cell_value)
			report_mismatch($sformatf("cell_value %h, want %h", got.cell_value, want.cell_value));
	endtask

	// Sample replies at the rising edge; ready was set at the falling edge before it.
	always @(posedge clk)
		if (arst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1)
			check_reply();

	// Guard against a hung block.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Reply side: random stalls in windows of varying density, plus one long hold-off
	// on request so the block backs up and stalls the command side.
	initial begin : reply_sink
		int stall_left;
		int stall_pct;
		int window;
		stall_left = 0;
		stall_pct  = 0;
		window     = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left   = HOLD_CYCLES;
			end
			if (window == 0) begin
				window = 200;
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 10;
					default: stall_pct = 35;
				endcase
			end
			window--;
			if (stall_left > 0) begin
				res_if.ready <= 1'b0;
				stall_left--;
			end else if ($urandom_range(0, 99) < stall_pct) begin
				res_if.ready <= 1'b0;
				stall_left = gap_len() - 1;
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		result_t typed_word;
		int      target;
		// Drive everything to a known value before the first edge.
		arst_n            = 1'b0;
		cfg_wr_en         = 1'b0;
		cfg_wr_data       = '0;
		cmd_if.valid      = 1'b0;
		cmd_if.cmd        = CMD_PUT;
		cmd_if.char_code  = '0;
		cmd_if.cell_index = '0;
		res_if.ready      = 1'b0;
		for (int k = 0; k < CELLS; k++)
			screen_model[k] = {RESET_COLOR, CHAR_SPACE};
		cur_row   = 0;
		cur_col   = 0;
		text_attr = RESET_COLOR;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Opening script at the reset colour; the block is still clearing, so the
		// first word simply waits for ready.
		foreach (opening_script[i]) begin
			typed_word.cursor_row      = ROW_OUT_W'(opening_script[i].row);
			typed_word.cursor_column   = COL_OUT_W'(opening_script[i].col);
			typed_word.cursor_position =
				POS_OUT_W'(opening_script[i].row * COLS + opening_script[i].col);
			typed_word.cell_value      = CELL_W'(opening_script[i].want_cell);
			send_word(opening_script[i].cmd, opening_script[i].ch,
				INDEX_W'(opening_script[i].idx), opening_script[i].typed, typed_word);
		end

		// Random phases, each with its own colour: black, white, then random ones.
		for (int phase = 0; phase < PHASES; phase++) begin
			settle();
			if (phase == 0)
				set_colour(8'h00);
			else if (phase == 1)
				set_colour(8'hFF);
			else
				set_colour(CHAR_W'($urandom_range(0, 255)));
			if (phase == 1)
				hold_request = 1'b1;
			target = words_sent + PHASE_WORDS;
			if (phase == 0) begin
				// Run down to the bottom row and past it, then wrap a line off the bottom.
				cmd_idle_pct = 10;
				repeat (24)
					send_word(CMD_PUT, CHAR_NEWLINE, INDEX_W'($urandom));
				type_text(90);
			end
			while (words_sent < target)
				run_segment();
		end

		settle();
		// Then wait for any stray reply word to show up.
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
